/* src/asert_pkg.sv */
// ----------------------------------------------------------------------------
// asert_pkg
// Shared types and constants for the scheduled difficulty target pipeline.
// ----------------------------------------------------------------------------
package asert_pkg;

   localparam int TARGET_WIDTH_DEF = 256;
   localparam int FRAC_BITS        = 16;
   localparam int DIV_STAGES       = 24;
   localparam int QUOT_WIDTH       = 24;

   localparam logic [47:0] POLY_C1 = 48'd195766423245049;
   localparam logic [29:0] POLY_C2 = 30'd971821376;
   localparam logic [12:0] POLY_C3 = 13'd5127;
   localparam logic [63:0] POLY_RND = 64'h0000_8000_0000_0000;
   localparam logic [16:0] FACTOR_ONE = 17'd65536;

   typedef enum logic [2:0] {
      CSR_ANCHOR_PARENT_TIME = 3'd0,
      CSR_ANCHOR_HEIGHT      = 3'd1,
      CSR_TARGET_SPACING     = 3'd2,
      CSR_HALF_LIFE          = 3'd3,
      CSR_ANCHOR_BITS        = 3'd4,
      CSR_LIMIT_BITS         = 3'd5,
      CSR_NO_RETARGET        = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic        bypass;
      logic [31:0] bits;
      logic        neg;
      logic        sat_hi;
      logic        sat_lo;
   } meta_type;

endpackage

/* src/asert_div.sv */
// ----------------------------------------------------------------------------
// asert_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module asert_div (
   input  logic                           clock,
   input  logic                           en,
   input  logic [23:0]                    divisor,
   input  logic [23:0]                    rem_in,
   input  logic [7:0]                     num_in,
   output logic [asert_pkg::QUOT_WIDTH-1:0] quot
);
   import asert_pkg::*;

   logic [23:0] rem_ff [DIV_STAGES];
   logic [23:0] wrd_ff [DIV_STAGES];
   logic [23:0] rem_in_s [DIV_STAGES];
   logic [23:0] wrd_in_s [DIV_STAGES];

   always_comb begin
      logic [23:0] rp;
      logic [23:0] wp;
      logic [24:0] r2;
      logic        ge;
      for (int i = 0; i < DIV_STAGES; i++) begin
         rp = (i == 0) ? rem_in : rem_ff[(i == 0) ? 0 : i - 1];
         wp = (i == 0) ? {num_in, 16'd0} : wrd_ff[(i == 0) ? 0 : i - 1];
         r2 = {rp, wp[23]};
         ge = (r2 >= {1'b0, divisor});
         rem_in_s[i] = ge ? 24'(r2 - {1'b0, divisor}) : r2[23:0];
         wrd_in_s[i] = {wp[22:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < DIV_STAGES; i++) begin
            rem_ff[i] <= rem_in_s[i];
            wrd_ff[i] <= wrd_in_s[i];
         end
      end
   end

   assign quot = wrd_ff[DIV_STAGES-1];

endmodule

/* src/asert_enc.sv */
// ----------------------------------------------------------------------------
// asert_enc
// Three-stage compact target encoder: byte scan, size, mantissa.
// ----------------------------------------------------------------------------
module asert_enc #(
   parameter int TARGET_WIDTH = asert_pkg::TARGET_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic                    in_bypass,
   input  logic [31:0]             in_bits,
   input  logic [TARGET_WIDTH-1:0] in_val,
   output logic                    out_valid,
   output logic [31:0]             out_bits
);
   import asert_pkg::*;

   localparam int NB  = (TARGET_WIDTH + 7) / 8;
   localparam int SZW = $clog2(NB + 2);

   logic              v1_ff, v2_ff, v3_ff;
   logic              b1_ff, b2_ff;
   logic [31:0]       k1_ff, k2_ff;
   logic [NB*8-1:0]   val1_ff, val2_ff;
   logic [NB-1:0]     nz1_ff;
   logic [SZW-1:0]    size2_ff;
   logic [31:0]       out_ff;
   logic [NB-1:0]     nz_in;
   logic [SZW-1:0]    size_in;
   logic [31:0]       out_in;

   always_comb begin
      logic [NB*8-1:0] vp;
      vp = (NB*8)'(in_val);
      for (int i = 0; i < NB; i++) nz_in[i] = |vp[8*i +: 8];
   end

   always_comb begin
      size_in = '0;
      for (int i = 0; i < NB; i++) begin
         if (nz1_ff[i]) size_in = SZW'(i + 1);
      end
   end

   always_comb begin
      logic [23:0]    m24;
      logic [SZW-1:0] sz;
      if (size2_ff <= SZW'(3)) begin
         m24 = val2_ff[23:0] << (8 * (3 - int'(size2_ff)));
      end else begin
         m24 = 24'(val2_ff >> (8 * (int'(size2_ff) - 3)));
      end
      sz = size2_ff;
      if (m24[23]) begin
         m24 = m24 >> 8;
         sz  = sz + SZW'(1);
      end
      out_in = b2_ff ? k2_ff : {8'(sz), 1'b0, m24[22:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b1_ff    <= in_bypass;
         k1_ff    <= in_bits;
         val1_ff  <= (NB*8)'(in_val);
         nz1_ff   <= nz_in;
         b2_ff    <= b1_ff;
         k2_ff    <= k1_ff;
         val2_ff  <= val1_ff;
         size2_ff <= size_in;
         out_ff   <= out_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_bits  = out_ff;

endmodule

/* src/asert_difficulty_target_core.sv */
// ----------------------------------------------------------------------------
// asert_difficulty_target_core
// Absolutely scheduled exponential difficulty target, fully pipelined.
// ----------------------------------------------------------------------------
// One request per clock unless held; each request returns one compact target
// after 3 deviation stages, 24 divider stages, 1 exponent split, 4 polynomial
// stages, 4 target scaling stages and 3 encoder stages. The whole pipeline
// holds while a result waits on rsp_tready, and req_tready is low only then.
// The 24-stage radix-2 divider for deviation / half-life sets the latency.
// ----------------------------------------------------------------------------
module asert_difficulty_target_core #(
   parameter int TARGET_WIDTH = asert_pkg::TARGET_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [31:0] last_block_time, [62:32] last_height, [94:63] last_bits, [95] zero
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] next_bits
   output logic [31:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   import asert_pkg::*;

   localparam int W  = TARGET_WIDTH;
   localparam int SW = $clog2(W);

   // configuration
   logic [31:0] apt_ff;
   logic [30:0] ah_ff;
   logic [16:0] ts_ff;
   logic [23:0] hl_ff;
   logic [31:0] ab_ff;
   logic [31:0] lb_ff;
   logic        nr_ff;
   logic [W-1:0]  lim_ff;
   logic [22:0]   am_ff;
   logic [SW-1:0] als_ff;
   logic [23:0]   hle;

   function automatic logic [W-1:0] dec_f(input logic [31:0] bits);
      int          sz;
      int          sh;
      logic [22:0] word;
      sz   = int'(bits[31:24]);
      word = bits[22:0];
      if (sz <= 3) begin
         dec_f = W'(word >> (8 * (3 - sz)));
      end else begin
         sh = 8 * (sz - 3);
         if (sh >= W) dec_f = '0;
         else dec_f = W'(word) << sh;
      end
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         apt_ff <= 32'd0;
         ah_ff  <= 31'd0;
         ts_ff  <= 17'd600;
         hl_ff  <= 24'd172800;
         ab_ff  <= 32'h1D00FFFF;
         lb_ff  <= 32'h1D00FFFF;
         nr_ff  <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ANCHOR_PARENT_TIME: apt_ff <= csr_data;
            CSR_ANCHOR_HEIGHT:      ah_ff  <= csr_data[30:0];
            CSR_TARGET_SPACING:     ts_ff  <= csr_data[16:0];
            CSR_HALF_LIFE:          hl_ff  <= csr_data[23:0];
            CSR_ANCHOR_BITS:        ab_ff  <= csr_data;
            CSR_LIMIT_BITS:         lb_ff  <= csr_data;
            CSR_NO_RETARGET:        nr_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      int           sz;
      int           sh;
      logic [W-1:0] a;
      sz = int'(ab_ff[31:24]);
      sh = 8 * (sz - 3);
      a  = dec_f(ab_ff);
      lim_ff <= dec_f(lb_ff);
      if (sz > 3 && sh < W) begin
         als_ff <= SW'(sh);
         am_ff  <= 23'(a >> sh);
      end else begin
         als_ff <= '0;
         am_ff  <= 23'(a);
      end
   end

   assign hle = (hl_ff == 24'd0) ? 24'd1 : hl_ff;

   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // deviation stages
   logic               v1_ff, v2_ff, v3_ff;
   meta_type           m1_ff, m2_ff, m3_ff, m1_in;
   logic signed [32:0] td1_ff, hd1_ff, td2_ff;
   logic signed [50:0] pr2_ff;
   logic               neg3_ff;
   logic [50:0]        mag3_ff;
   logic signed [50:0] dev;

   always_comb begin
      m1_in.bypass = nr_ff;
      m1_in.bits   = req_tdata[94:63];
      m1_in.neg    = 1'b0;
      m1_in.sat_hi = 1'b0;
      m1_in.sat_lo = 1'b0;
      dev = 51'(td2_ff) - pr2_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff   <= m1_in;
         td1_ff  <= $signed({1'b0, req_tdata[31:0]}) - $signed({1'b0, apt_ff});
         hd1_ff  <= $signed({2'b00, req_tdata[62:32]}) + 33'sd1
                    - $signed({2'b00, ah_ff});
         m2_ff   <= m1_ff;
         td2_ff  <= td1_ff;
         pr2_ff  <= 51'($signed({1'b0, ts_ff}) * hd1_ff);
         m3_ff   <= m2_ff;
         neg3_ff <= dev[50];
         mag3_ff <= dev[50] ? 51'(-dev) : 51'(dev);
      end
   end

   // divider with matching metadata line
   logic        vd_ff [DIV_STAGES];
   meta_type    md_ff [DIV_STAGES];
   meta_type    md_in;
   logic        ovf;
   logic [QUOT_WIDTH-1:0] quot;

   always_comb begin
      ovf          = (mag3_ff >= (51'(hle) << 8));
      md_in        = m3_ff;
      md_in.neg    = neg3_ff;
      md_in.sat_hi = ovf && !neg3_ff;
      md_in.sat_lo = ovf && neg3_ff;
   end

   asert_div u_div (
      .clock   (clock),
      .en      (en),
      .divisor (hle),
      .rem_in  (mag3_ff[31:8]),
      .num_in  (mag3_ff[7:0]),
      .quot    (quot)
   );

   // exponent split
   logic              vf_ff;
   meta_type          mf_ff, mf_in;
   logic signed [9:0] sf_ff, sf_in;
   logic [15:0]       ff_ff, ff_in;

   always_comb begin
      logic [7:0]  qi;
      logic [15:0] qf;
      qi    = quot[23:16];
      qf    = quot[15:0];
      mf_in = md_ff[DIV_STAGES-1];
      if (!mf_in.neg) begin
         sf_in = $signed({2'b00, qi});
         ff_in = qf;
      end else if (qf != 16'd0) begin
         sf_in = -$signed({2'b00, qi}) - 10'sd1;
         ff_in = 16'(-qf);
         if (qi == 8'hFF) mf_in.sat_lo = 1'b1;
      end else begin
         sf_in = -$signed({2'b00, qi});
         ff_in = 16'd0;
      end
   end

   // polynomial stages
   logic              vp_ff [4];
   meta_type          mp_ff [4];
   logic signed [9:0] sp_ff [4];
   logic [15:0] f1_ff;
   logic [39:0] ah1_ff, al1_ff;
   logic [31:0] sq1_ff;
   logic [63:0] t1_ff, t2_ff, t12_ff, t3_ff;
   logic [47:0] cu2_ff;
   logic [16:0] fac_ff;
   logic [63:0] psum;

   assign psum = t12_ff + t3_ff + POLY_RND;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < DIV_STAGES; i++) begin
            md_ff[i] <= (i == 0) ? md_in : md_ff[(i == 0) ? 0 : i - 1];
         end
         mf_ff <= mf_in;
         sf_ff <= sf_in;
         ff_ff <= ff_in;
         mp_ff[0] <= mf_ff;
         sp_ff[0] <= sf_ff;
         for (int i = 1; i < 4; i++) begin
            mp_ff[i] <= mp_ff[i-1];
            sp_ff[i] <= sp_ff[i-1];
         end
         f1_ff  <= ff_ff;
         ah1_ff <= POLY_C1[47:24] * ff_ff;
         al1_ff <= POLY_C1[23:0] * ff_ff;
         sq1_ff <= ff_ff * ff_ff;
         t1_ff  <= (64'(ah1_ff) << 24) + 64'(al1_ff);
         t2_ff  <= 64'(POLY_C2 * sq1_ff);
         cu2_ff <= sq1_ff * f1_ff;
         t12_ff <= t1_ff + t2_ff;
         t3_ff  <= 64'(POLY_C3 * cu2_ff);
         fac_ff <= FACTOR_ONE + {1'b0, psum[63:48]};
      end
   end

   // target scaling
   logic              vx_ff, vt_ff, vc_ff, ve_ff;
   meta_type          mx_ff, mt_ff, mc_ff, me_ff;
   logic signed [9:0] sx_ff, st_ff;
   logic [39:0]       x_ff;
   logic [W:0]        t_ff, vcv_ff;
   logic              ovp_ff;
   logic [W-1:0]      ev_ff, ev_in;
   logic [W:0]        vc_in;
   logic              ovp_in;
   logic [W+16:0]     zsh;

   assign zsh = (W+17)'(x_ff) << als_ff;

   always_comb begin
      logic [7:0] spos;
      logic [7:0] sneg;
      spos = st_ff[7:0];
      sneg = 8'(-st_ff);
      if (st_ff > 10'sd0) begin
         if (int'(spos) >= W) ovp_in = (int'(spos) > W) || (|t_ff);
         else ovp_in = |(t_ff >> (W - int'(spos)));
         vc_in = {1'b0, W'(t_ff << spos)};
      end else begin
         ovp_in = 1'b0;
         vc_in  = t_ff >> sneg;
      end
   end

   always_comb begin
      logic [W:0] v;
      v = (vcv_ff == '0) ? (W+1)'(1) : vcv_ff;
      if (mc_ff.sat_hi || ovp_ff) ev_in = lim_ff;
      else if (mc_ff.sat_lo) ev_in = W'(1);
      else if (v > {1'b0, lim_ff}) ev_in = lim_ff;
      else ev_in = W'(v);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mx_ff  <= mp_ff[3];
         sx_ff  <= sp_ff[3];
         x_ff   <= am_ff * fac_ff;
         mt_ff  <= mx_ff;
         st_ff  <= sx_ff;
         t_ff   <= zsh[W+16:16];
         mc_ff  <= mt_ff;
         vcv_ff <= vc_in;
         ovp_ff <= ovp_in;
         me_ff  <= mc_ff;
         ev_ff  <= ev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         for (int i = 0; i < DIV_STAGES; i++) vd_ff[i] <= 1'b0;
         vf_ff <= 1'b0;
         for (int i = 0; i < 4; i++) vp_ff[i] <= 1'b0;
         vx_ff <= 1'b0;
         vt_ff <= 1'b0;
         vc_ff <= 1'b0;
         ve_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         for (int i = 0; i < DIV_STAGES; i++) begin
            vd_ff[i] <= (i == 0) ? v3_ff : vd_ff[(i == 0) ? 0 : i - 1];
         end
         vf_ff    <= vd_ff[DIV_STAGES-1];
         vp_ff[0] <= vf_ff;
         for (int i = 1; i < 4; i++) vp_ff[i] <= vp_ff[i-1];
         vx_ff <= vp_ff[3];
         vt_ff <= vx_ff;
         vc_ff <= vt_ff;
         ve_ff <= vc_ff;
      end
   end

   asert_enc #(
      .TARGET_WIDTH (TARGET_WIDTH)
   ) u_enc (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (ve_ff),
      .in_bypass (me_ff.bypass),
      .in_bits   (me_ff.bits),
      .in_val    (ev_ff),
      .out_valid (rsp_tvalid),
      .out_bits  (rsp_tdata)
   );

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the scheduled difficulty target core: a predictor
// computes the next compact target for every accepted request, a monitor
// compares each response in order, with random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
   import asert_pkg::*;

   localparam int TW = 256;
   localparam int LAT = 39;

   typedef struct packed {
      logic [31:0] bits;
      logic [30:0] height;
      logic [31:0] stamp;
   } hdr_type;

   logic        clock, reset;
   logic        req_tvalid, req_tready;
   logic [95:0] req_tdata;
   logic        rsp_tvalid, rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_valid, csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;

   asert_difficulty_target_core u_dut (.*);

   // predictor configuration copy
   logic [31:0] cf_parent_time = 0;
   logic [30:0] cf_anchor_height = 0;
   logic [16:0] cf_spacing = 600;
   logic [23:0] cf_half_life = 172800;
   logic [31:0] cf_anchor_bits = 32'h1D00FFFF;
   logic [31:0] cf_limit_bits = 32'h1D00FFFF;
   logic        cf_no_retarget = 0;

   hdr_type     hdr_q[$];
   logic [31:0] target_q[$];
   int          errors = 0, n_rsp = 0;
   int          req_gap = 0, rsp_gap = 0, hold_off = 0;
   bit          quiet = 0, req_acc = 0;

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("FAILURE");
      $finish;
   end

   function automatic logic [TW:0] decode_bits(logic [31:0] b);
      logic [TW+16:0] v;
      v = b[22:0];
      if (b[31:24] <= 3) v = v >> (8 * (3 - b[31:24]));
      else v = v << (8 * (b[31:24] - 3));
      return v[TW-1:0];
   endfunction

   function automatic int bitlen(logic [TW+16:0] v);
      for (int i = TW + 16; i >= 0; i--) if (v[i]) return i + 1;
      return 0;
   endfunction

   function automatic logic [31:0] encode_bits(logic [TW:0] v);
      int sz;
      logic [TW:0] t;
      logic [31:0] mant;
      sz = (bitlen(v) + 7) / 8;
      if (sz <= 3) t = v << (8 * (3 - sz));
      else t = v >> (8 * (sz - 3));
      mant = {8'd0, t[23:0]};
      if (mant[23]) begin
         mant = mant >> 8;
         sz++;
      end
      return {sz[7:0], 1'b0, mant[22:0]};
   endfunction

   function automatic logic [31:0] next_target(hdr_type h);
      longint dev, sh;
      logic [63:0] mag, hl, qi, qf, f, s;
      logic [31:0] frac, factor;
      logic [TW+16:0] tg;
      logic [TW:0] lim;
      if (cf_no_retarget) return h.bits;
      lim = decode_bits(cf_limit_bits);
      dev = (longint'(h.stamp) - longint'(cf_parent_time))
          - longint'(cf_spacing) * (longint'(h.height) + 1 - longint'(cf_anchor_height));
      hl = cf_half_life == 0 ? 1 : cf_half_life;
      mag = dev < 0 ? -dev : dev;
      qi = mag / hl;
      qf = ((mag % hl) << 16) / hl;
      if (dev >= 0) begin
         if (qi >= 256) return encode_bits(lim);
         sh = qi;
         frac = qf;
      end else begin
         if (qi >= 256) return encode_bits(1);
         sh = -longint'(qi);
         frac = 0;
         if (qf != 0) begin
            sh--;
            frac = 65536 - qf;
         end
         if (sh <= -256) return encode_bits(1);
      end
      factor = 65536;
      if (frac != 0) begin
         f = frac;
         s = 64'd195766423245049 * f + 64'd971821376 * f * f + 64'd5127 * f * f * f
           + (64'd1 << 47);
         factor = 65536 + s[63:48];
      end
      tg = decode_bits(cf_anchor_bits);
      tg = (tg * factor) >> 16;
      if (sh > 0) begin
         if (bitlen(tg) + sh > TW) return encode_bits(lim);
         tg = tg << sh;
      end else if (sh < 0) tg = tg >> (-sh);
      if (tg == 0) tg = 1;
      if (tg > lim) tg = lim;
      return encode_bits(tg[TW:0]);
   endfunction

   task automatic add_hdr(logic [31:0] t, logic [30:0] h, logic [31:0] b);
      hdr_type x;
      x = '{bits: b, height: h, stamp: t};
      hdr_q.push_back(x);
   endtask

   task automatic csr_write(csr_index_type idx, logic [31:0] v);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 0;
      case (idx)
         CSR_ANCHOR_PARENT_TIME: cf_parent_time = v;
         CSR_ANCHOR_HEIGHT:      cf_anchor_height = v[30:0];
         CSR_TARGET_SPACING:     cf_spacing = v[16:0];
         CSR_HALF_LIFE:          cf_half_life = v[23:0];
         CSR_ANCHOR_BITS:        cf_anchor_bits = v;
         CSR_LIMIT_BITS:         cf_limit_bits = v;
         default:                cf_no_retarget = v[0];
      endcase
   endtask

   task automatic drain;
      wait (hdr_q.size() == 0 && target_q.size() == 0);
      repeat (LAT + 10) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_bits;
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return {8'($urandom_range(0, 4)), 24'($urandom)};
         default: return {8'($urandom_range(0, 33)), 24'($urandom)};
      endcase
   endfunction

   // chain-like headers: times scattered around the schedule
   task automatic add_chain(int n);
      logic [30:0] h;
      longint t;
      h = cf_anchor_height + $urandom_range(0, 5000);
      for (int i = 0; i < n; i++) begin
         t = longint'(cf_parent_time) + longint'(cf_spacing) * (h + 1 - cf_anchor_height);
         case ($urandom_range(0, 3))
            0: t += $urandom_range(0, 4 * cf_half_life);
            1: t -= $urandom_range(0, 4 * cf_half_life);
            2: t += longint'($signed($urandom_range(0, 2000))) - 1000;
            default: t = $urandom;
         endcase
         add_hdr(t[31:0], ($urandom_range(0, 9) == 0) ? 31'($urandom) : h, rand_bits());
         h++;
      end
   endtask

   // request acceptance and prediction
   always @(posedge clock) begin
      if (reset) req_acc = 0;
      else begin
         req_acc = req_tvalid && req_tready;
         if (req_acc) target_q.push_back(next_target(hdr_q.pop_front()));
      end
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
         req_tdata <= 0;
      end else if (req_tvalid && !req_acc) begin
         // pending request stays on the bus
      end else if (req_gap > 0) begin
         req_gap <= req_gap - 1;
         req_tvalid <= 0;
      end else if (hdr_q.size() > 0) begin
         if (!quiet && $urandom_range(0, 9) == 0) begin
            req_gap <= $urandom_range(1, 14) - 1;
            req_tvalid <= 0;
         end else begin
            req_tvalid <= 1;
            req_tdata <= {1'b0, hdr_q[0]};
         end
      end else req_tvalid <= 0;
   end

   // receiver stall
   always @(negedge clock) begin
      if (reset) rsp_tready <= 0;
      else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 0;
      end else if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_tready <= 0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         rsp_gap <= $urandom_range(1, 14) - 1;
         rsp_tready <= 0;
      end else rsp_tready <= 1;
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_rsp++;
         if (target_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response %h", rsp_tdata);
         end else begin
            if (rsp_tdata !== target_q[0]) begin
               errors++;
               if (errors <= 10)
                  $display("next_bits mismatch: exp %h got %h", target_q[0], rsp_tdata);
            end
            void'(target_q.pop_front());
         end
      end
   end

   initial begin
      reset = 1;
      csr_valid = 0;
      csr_index = CSR_ANCHOR_PARENT_TIME;
      csr_data = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: reset settings
      add_hdr(0, 0, 0);
      add_hdr(32'hFFFFFFFF, 31'h7FFFFFFE, 32'hFFFFFFFF);
      add_hdr(600, 0, 32'h1D00FFFF);
      add_hdr(600 + 172800 * 300, 0, 0);
      add_hdr(0, 31'd100000, 0);
      add_hdr(600 + 172800, 0, 0);
      add_hdr(600 - 172800, 0, 0);
      add_hdr(600 + 86400, 0, 0);
      add_hdr(600 + 1, 0, 0);
      add_hdr(600 + 172800 * 20, 0, 0);
      drain();
      csr_write(CSR_ANCHOR_BITS, 32'h01003456);
      csr_write(CSR_LIMIT_BITS, 0);
      csr_write(CSR_HALF_LIFE, 0);
      add_hdr(600, 0, 0);
      add_hdr(0, 0, 0);
      add_hdr(700, 0, 0);
      add_hdr(32'hFFFFFFFF, 0, 0);
      drain();
      csr_write(CSR_LIMIT_BITS, 32'hFF7FFFFF);
      csr_write(CSR_ANCHOR_BITS, 32'h2100FFFF);
      csr_write(CSR_HALF_LIFE, 24'hFFFFFF);
      add_hdr(600 + 24'hFFFFFF * 3, 0, 0);
      add_hdr(32'hFFFFFFFF, 0, 0);
      drain();
      csr_write(CSR_NO_RETARGET, 1);
      add_hdr($urandom, 5, 32'hDEADBEEF);
      add_hdr(0, 0, 32'h00800000);
      drain();
      csr_write(CSR_NO_RETARGET, 0);

      // pressure: long receiver hold while the sender keeps offering
      hold_off = 150;
      add_chain(100);
      drain();

      for (int p = 0; p < 12; p++) begin
         csr_write(CSR_ANCHOR_PARENT_TIME, (p == 1) ? 32'hFFFFFFFF : $urandom);
         csr_write(CSR_ANCHOR_HEIGHT, (p == 2) ? 32'h7FFFFFFF : $urandom_range(0, 100000));
         csr_write(CSR_TARGET_SPACING, (p == 3) ? 1 : (p == 4) ? 86400 : $urandom_range(1, 1200));
         csr_write(CSR_HALF_LIFE, (p == 5) ? 1 : (p == 6) ? 24'hFFFFFF
                                  : $urandom_range(1, 400000));
         csr_write(CSR_ANCHOR_BITS, rand_bits());
         csr_write(CSR_LIMIT_BITS, ($urandom_range(0, 2) == 0) ? rand_bits() : 32'h2100FFFF);
         csr_write(CSR_NO_RETARGET, p == 7);
         if (p == 11) quiet = 1;
         add_chain(143);
         for (int i = 0; i < 10; i++) add_hdr($urandom, $urandom, $urandom);
         drain();
      end

      $display("covered %0d responses over 12 random register settings plus directed", n_rsp);
      $display("cases, including saturation, bypass, zero limit and a long output stall");
      if (errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule
